// File: sv/vgrt_pkg.sv
package vgrt_pkg;

	localparam int DW = 64;

	localparam logic [2:0] FACE_NONE = 3'd6;

	localparam logic [1:0] CFG_RES_X = 2'd0;
	localparam logic [1:0] CFG_RES_Y = 2'd1;
	localparam logic [1:0] CFG_RES_Z = 2'd2;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_TRACE = 1'b1;

	typedef struct packed {
		logic               mode;
		logic [11:0]        voxel_address;
		logic               voxel_occupied;
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] direction_x;
		logic signed [31:0] direction_y;
		logic signed [31:0] direction_z;
		logic signed [31:0] interval_start;
		logic signed [31:0] interval_end;
	} in_item_t;

	typedef struct packed {
		logic               hit;
		logic [2:0]         face;
		logic signed [31:0] hit_distance;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SLAB_CHK,
		ST_SLAB_W1,
		ST_SLAB_W2,
		ST_SLAB_CMP,
		ST_ENT_MUL,
		ST_ENT_POS,
		ST_ENT_IDX,
		ST_ENT_TN,
		ST_ENT_W,
		ST_START_RD,
		ST_START,
		ST_LOOP_RD,
		ST_LOOP_CHK,
		ST_LOOP_W,
		ST_EMIT
	} state_t;

endpackage

// File: sv/vgrt_occ_mem.sv
module vgrt_occ_mem #(
	parameter int DEPTH = 4096,
	parameter int AW = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic          wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic          rd_data,
	output logic          busy
);

	logic          mem [DEPTH];
	logic [AW-1:0] clr_q;
	logic          busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			clr_q <= clr_q + AW'(1);
			if (clr_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= 1'b0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

	assign busy = busy_q;

endmodule

// File: sv/vgrt_div.sv
module vgrt_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [vgrt_pkg::DW-1:0] num,
	input  logic signed [vgrt_pkg::DW-1:0] den,
	output logic                         done,
	output logic signed [vgrt_pkg::DW-1:0] quo
);

	localparam int DW = vgrt_pkg::DW;
	localparam int CW = $clog2(DW + 1);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] quo_q;
	logic [DW-1:0] dmag_q;
	logic          neg_q;
	logic          zero_q;
	logic [DW:0]   sh;
	logic [DW:0]   trial;

	always_comb begin
		sh    = {rem_q[DW-1:0], quo_q[DW-1]};
		trial = sh - {1'b0, dmag_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DW);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= num[DW-1] ? (~num + DW'(1)) : num;
			dmag_q <= den[DW-1] ? (~den + DW'(1)) : den;
			neg_q  <= num[DW-1] ^ den[DW-1];
			zero_q <= (den == '0);
		end else if (run_q) begin
			rem_q <= trial[DW] ? sh : trial;
			quo_q <= {quo_q[DW-2:0], ~trial[DW]};
		end
	end

	assign done = done_q;
	assign quo  = zero_q ? '0 : (neg_q ? -$signed(quo_q) : $signed(quo_q));

endmodule

// File: sv/voxel_grid_ray_traversal.sv
// Ray caster over a voxel grid filling [-1,1]^3, Q(32-FRACTION_BITS).FRACTION_BITS
// fixed point. After reset the occupancy memory is cleared, all MAX_RESOLUTION^3
// entries (4096 by default), with in_ready low; configuration writes are taken
// meanwhile. A mode-0 item writes one occupancy bit and the block stays idle.
// A mode-1 item is paced by the shared 64-bit bit-serial divider, one division
// per boundary parameter: up to six for the slab test, up to three for the entry
// boundaries and one per voxel step (at most 3*MAX_RESOLUTION+4 steps). The
// result waits in an output register while the next item is taken.
module voxel_grid_ray_traversal #(
	parameter int MAX_RESOLUTION = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  vgrt_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output vgrt_pkg::out_item_t out_item,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_addr,
	input  logic [4:0]          cfg_wdata
);

	localparam int NW = $clog2(MAX_RESOLUTION + 1);
	localparam int IW = $clog2(MAX_RESOLUTION);
	localparam int DEPTH = MAX_RESOLUTION * MAX_RESOLUTION * MAX_RESOLUTION;
	localparam int AW = $clog2(DEPTH);
	localparam int LIMIT = 3 * MAX_RESOLUTION + 4;
	localparam int TW = $clog2(LIMIT + 1);
	localparam int MW = 32 + NW + 1;
	localparam longint ONE = longint'(1) << FRACTION_BITS;
	localparam longint PAR_LIMIT = (ONE - 1) / 1000000;
	localparam logic signed [63:0] T_INF = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
	localparam logic signed [63:0] I32_MIN = -64'sd2147483648;

	vgrt_pkg::state_t state_q, state_d;

	logic [4:0]         res_q [3];
	logic [NW-1:0]      n_eff [3];
	logic signed [31:0] org_q [3];
	logic signed [31:0] dir_q [3];
	logic [IW-1:0]      idx_q [3];
	logic signed [63:0] tnext_q [3];
	logic               par_q [3];
	logic signed [63:0] tmin_q, tmax_q, t1_q, prod_q, v_q;
	logic [2:0]         face_q;
	logic               face_v_q, in_cube_q, start_q;
	logic [TW-1:0]      iter_q;
	logic [1:0]         ax_q;
	vgrt_pkg::out_item_t res_item_q, out_q;
	logic               out_valid_q;

	logic               accept, out_free;
	logic [1:0]         cur, sel;
	logic signed [31:0] o_c, d_c;
	logic [NW-1:0]      n_c, k_c;
	logic [IW-1:0]      idx_c;
	logic signed [NW:0] n_s;
	logic               dpos_c, dzero_c, outside_c, par_c;
	logic [32:0]        dmag_c;
	logic signed [NW+1:0] k2mn;
	logic signed [MW-1:0] no_c, nd_c;
	logic signed [63:0] pl_num, div_num, div_den, div_quo;
	logic               div_start, div_done;
	logic signed [63:0] pq_c, p_c, vq_c, mul_c, sat_c, tn_sel;
	logic               stop_c, solid, mem_busy, mem_we;
	logic [AW-1:0]      rd_addr;
	logic [2:0]         hit_face;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == vgrt_pkg::ST_IDLE) && !mem_busy;
	assign out_free = !out_valid_q || out_ready;
	assign mem_we   = accept && (in_item.mode == vgrt_pkg::MODE_WRITE)
		&& (32'(in_item.voxel_address) < DEPTH);
	assign rd_addr  = AW'((AW'(idx_q[2]) * AW'(MAX_RESOLUTION) + AW'(idx_q[1]))
		* AW'(MAX_RESOLUTION) + AW'(idx_q[0]));

	vgrt_occ_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mem_we),
		.wr_addr (AW'(in_item.voxel_address)),
		.wr_data (in_item.voxel_occupied),
		.rd_addr (rd_addr),
		.rd_data (solid),
		.busy    (mem_busy)
	);

	vgrt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			if (res_q[a] == 5'd0) begin
				n_eff[a] = NW'(1);
			end else if (32'(res_q[a]) > MAX_RESOLUTION) begin
				n_eff[a] = NW'(MAX_RESOLUTION);
			end else begin
				n_eff[a] = NW'(res_q[a]);
			end
		end
	end

	always_comb begin
		if (tnext_q[0] < tnext_q[1] && tnext_q[0] < tnext_q[2]) begin
			sel = 2'd0;
		end else if (tnext_q[1] < tnext_q[2]) begin
			sel = 2'd1;
		end else begin
			sel = 2'd2;
		end
	end

	always_comb begin
		cur       = (state_q == vgrt_pkg::ST_LOOP_CHK) ? sel : ax_q;
		o_c       = org_q[cur];
		d_c       = dir_q[cur];
		n_c       = n_eff[cur];
		idx_c     = idx_q[cur];
		n_s       = {1'b0, n_c};
		dzero_c   = (d_c == '0);
		dpos_c    = !d_c[31] && !dzero_c;
		outside_c = (64'(o_c) < -ONE) || (64'(o_c) > ONE);
		dmag_c    = d_c[31] ? ({1'b0, ~d_c} + 33'd1) : {1'b0, d_c};
		par_c     = (dmag_c <= 33'(PAR_LIMIT));
		tn_sel    = tnext_q[sel];
		stop_c    = (tn_sel > tmax_q) || par_q[sel]
			|| (dpos_c ? (idx_c == IW'(n_c - NW'(1))) : (idx_c == '0));
		hit_face  = !face_v_q ? vgrt_pkg::FACE_NONE
			: (start_q ? {face_q[2:1], ~face_q[0]} : face_q);
	end

	always_comb begin
		div_start = 1'b0;
		k_c       = '0;
		unique case (state_q)
			vgrt_pkg::ST_SLAB_CHK: begin
				div_start = !dzero_c;
			end
			vgrt_pkg::ST_SLAB_W1: begin
				div_start = div_done;
				k_c       = n_c;
			end
			vgrt_pkg::ST_ENT_TN: begin
				div_start = !par_q[cur];
				k_c       = dpos_c ? (NW'(idx_c) + NW'(1)) : NW'(idx_c);
			end
			vgrt_pkg::ST_LOOP_CHK: begin
				div_start = (solid == start_q) && !stop_c;
				k_c       = dpos_c ? (NW'(idx_c) + NW'(2)) : (NW'(idx_c) - NW'(1));
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	always_comb begin
		k2mn    = $signed({1'b0, k_c, 1'b0}) - $signed({2'b0, n_c});
		no_c    = MW'(o_c) * MW'(n_s);
		nd_c    = MW'(d_c) * MW'(n_s);
		pl_num  = (64'(k2mn) <<< FRACTION_BITS) - 64'(no_c);
		div_num = pl_num <<< FRACTION_BITS;
		div_den = 64'(nd_c);
		mul_c   = $signed(tmin_q[31:0]) * d_c;
		pq_c    = prod_q[63] ? ((prod_q + (ONE - 1)) >>> FRACTION_BITS)
			: (prod_q >>> FRACTION_BITS);
		p_c     = 64'(o_c) + pq_c + ONE;
		vq_c    = v_q >>> (FRACTION_BITS + 1);
		if (tmin_q > I32_MAX) begin
			sat_c = I32_MAX;
		end else if (tmin_q < I32_MIN) begin
			sat_c = I32_MIN;
		end else begin
			sat_c = tmin_q;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vgrt_pkg::ST_IDLE: begin
				if (accept && in_item.mode == vgrt_pkg::MODE_TRACE) begin
					state_d = vgrt_pkg::ST_SLAB_CHK;
				end
			end
			vgrt_pkg::ST_SLAB_CHK: begin
				if (!dzero_c) begin
					state_d = vgrt_pkg::ST_SLAB_W1;
				end else if (outside_c) begin
					state_d = vgrt_pkg::ST_EMIT;
				end else if (ax_q == 2'd2) begin
					state_d = vgrt_pkg::ST_ENT_MUL;
				end
			end
			vgrt_pkg::ST_SLAB_W1: begin
				if (div_done) begin
					state_d = vgrt_pkg::ST_SLAB_W2;
				end
			end
			vgrt_pkg::ST_SLAB_W2: begin
				if (div_done) begin
					state_d = vgrt_pkg::ST_SLAB_CMP;
				end
			end
			vgrt_pkg::ST_SLAB_CMP: begin
				if (tmin_q > tmax_q) begin
					state_d = vgrt_pkg::ST_EMIT;
				end else if (ax_q == 2'd2) begin
					state_d = vgrt_pkg::ST_ENT_MUL;
				end else begin
					state_d = vgrt_pkg::ST_SLAB_CHK;
				end
			end
			vgrt_pkg::ST_ENT_MUL: state_d = vgrt_pkg::ST_ENT_POS;
			vgrt_pkg::ST_ENT_POS: state_d = vgrt_pkg::ST_ENT_IDX;
			vgrt_pkg::ST_ENT_IDX: state_d = vgrt_pkg::ST_ENT_TN;
			vgrt_pkg::ST_ENT_TN: begin
				if (!par_q[cur]) begin
					state_d = vgrt_pkg::ST_ENT_W;
				end else if (ax_q == 2'd2) begin
					state_d = vgrt_pkg::ST_START_RD;
				end else begin
					state_d = vgrt_pkg::ST_ENT_MUL;
				end
			end
			vgrt_pkg::ST_ENT_W: begin
				if (div_done) begin
					state_d = (ax_q == 2'd2) ? vgrt_pkg::ST_START_RD : vgrt_pkg::ST_ENT_MUL;
				end
			end
			vgrt_pkg::ST_START_RD: state_d = vgrt_pkg::ST_START;
			vgrt_pkg::ST_START: state_d = vgrt_pkg::ST_LOOP_RD;
			vgrt_pkg::ST_LOOP_RD: begin
				state_d = (iter_q == TW'(LIMIT)) ? vgrt_pkg::ST_EMIT : vgrt_pkg::ST_LOOP_CHK;
			end
			vgrt_pkg::ST_LOOP_CHK: begin
				if (solid != start_q || stop_c) begin
					state_d = vgrt_pkg::ST_EMIT;
				end else begin
					state_d = vgrt_pkg::ST_LOOP_W;
				end
			end
			vgrt_pkg::ST_LOOP_W: begin
				if (div_done) begin
					state_d = vgrt_pkg::ST_LOOP_RD;
				end
			end
			vgrt_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = vgrt_pkg::ST_IDLE;
				end
			end
			default: state_d = vgrt_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vgrt_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			for (int a = 0; a < 3; a++) begin
				res_q[a] <= 5'd1;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we && cfg_addr <= vgrt_pkg::CFG_RES_Z) begin
				res_q[cfg_addr] <= cfg_wdata;
			end
			if (state_q == vgrt_pkg::ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			vgrt_pkg::ST_IDLE: begin
				if (accept) begin
					org_q[0]  <= in_item.origin_x;
					org_q[1]  <= in_item.origin_y;
					org_q[2]  <= in_item.origin_z;
					dir_q[0]  <= in_item.direction_x;
					dir_q[1]  <= in_item.direction_y;
					dir_q[2]  <= in_item.direction_z;
					tmin_q    <= 64'(in_item.interval_start);
					tmax_q    <= 64'(in_item.interval_end);
					face_v_q  <= 1'b0;
					in_cube_q <= 1'b1;
					ax_q      <= 2'd0;
				end
			end
			vgrt_pkg::ST_SLAB_CHK: begin
				if (dzero_c) begin
					if (outside_c) begin
						res_item_q <= '{hit: 1'b0, face: vgrt_pkg::FACE_NONE, hit_distance: '0};
					end
					ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
				end
			end
			vgrt_pkg::ST_SLAB_W1: begin
				if (div_done) begin
					t1_q <= div_quo;
				end
			end
			vgrt_pkg::ST_SLAB_W2: begin
				if (div_done) begin
					if (dpos_c) begin
						if (t1_q > tmin_q) begin
							tmin_q   <= t1_q;
							face_q   <= {ax_q, 1'b0};
							face_v_q <= 1'b1;
						end
						if (div_quo < tmax_q) begin
							tmax_q <= div_quo;
						end
					end else begin
						if (div_quo > tmin_q) begin
							tmin_q   <= div_quo;
							face_q   <= {ax_q, 1'b1};
							face_v_q <= 1'b1;
						end
						if (t1_q < tmax_q) begin
							tmax_q <= t1_q;
						end
					end
				end
			end
			vgrt_pkg::ST_SLAB_CMP: begin
				res_item_q <= '{hit: 1'b0, face: vgrt_pkg::FACE_NONE, hit_distance: '0};
				ax_q       <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
			end
			vgrt_pkg::ST_ENT_MUL: begin
				prod_q <= mul_c;
			end
			vgrt_pkg::ST_ENT_POS: begin
				v_q <= 64'(p_c * n_s);
			end
			vgrt_pkg::ST_ENT_IDX: begin
				if (v_q[63]) begin
					idx_q[cur] <= '0;
				end else if (vq_c >= 64'(n_c)) begin
					idx_q[cur] <= IW'(n_c - NW'(1));
				end else begin
					idx_q[cur] <= vq_c[IW-1:0];
				end
				par_q[cur] <= par_c;
				if (outside_c) begin
					in_cube_q <= 1'b0;
				end
			end
			vgrt_pkg::ST_ENT_TN: begin
				if (par_q[cur]) begin
					tnext_q[cur] <= T_INF;
					ax_q         <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
				end
			end
			vgrt_pkg::ST_ENT_W: begin
				if (div_done) begin
					tnext_q[cur] <= div_quo;
					ax_q         <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
				end
			end
			vgrt_pkg::ST_START: begin
				start_q <= solid && in_cube_q;
				iter_q  <= '0;
			end
			vgrt_pkg::ST_LOOP_RD: begin
				res_item_q <= '{hit: 1'b0, face: vgrt_pkg::FACE_NONE, hit_distance: '0};
			end
			vgrt_pkg::ST_LOOP_CHK: begin
				if (solid != start_q) begin
					res_item_q <= '{hit: 1'b1, face: hit_face, hit_distance: sat_c[31:0]};
				end else begin
					ax_q     <= sel;
					face_q   <= {sel, !dpos_c};
					face_v_q <= 1'b1;
					tmin_q   <= tn_sel;
					if (!stop_c) begin
						idx_q[sel] <= dpos_c ? idx_c + IW'(1) : idx_c - IW'(1);
					end
				end
			end
			vgrt_pkg::ST_LOOP_W: begin
				if (div_done) begin
					tnext_q[cur] <= div_quo;
					iter_q       <= iter_q + TW'(1);
				end
			end
			vgrt_pkg::ST_EMIT: begin
				if (out_free) begin
					out_q <= res_item_q;
				end
			end
			default: begin
				out_q <= out_q;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_trace_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_item.mode == vgrt_pkg::MODE_TRACE) |=> (state_q != vgrt_pkg::ST_IDLE))
		else $error("trace item did not start a walk");

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == vgrt_pkg::ST_SLAB_W1 || state_q == vgrt_pkg::ST_SLAB_W2
			|| state_q == vgrt_pkg::ST_ENT_W || state_q == vgrt_pkg::ST_LOOP_W))
		else $error("divider finished outside a wait state");

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		mem_busy |-> !in_ready)
		else $error("item taken during occupancy clear");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vgrt_pkg::ST_LOOP_CHK) |-> (iter_q < TW'(LIMIT)))
		else $error("walk ran past step limit");

	a_emit_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vgrt_pkg::ST_EMIT && out_free) |=> out_valid_q)
		else $error("result not presented");

endmodule

// File: tb/sv/tb_voxel_grid_ray_traversal.sv
`timescale 1ns / 100ps

module tb_voxel_grid_ray_traversal;

	localparam int MAXR = 16;
	localparam longint ONE = 64'sd65536;
	localparam longint TINF = 64'sh7fffffffffffffff;
	localparam int NUM_RAND = 700;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	vgrt_pkg::in_item_t in_item;
	logic out_valid;
	logic out_ready;
	vgrt_pkg::out_item_t out_item;
	logic cfg_we;
	logic [1:0] cfg_addr;
	logic [4:0] cfg_wdata;

	voxel_grid_ray_traversal dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	bit occ_map[4096];
	logic [4:0] grid_res[3];
	vgrt_pkg::out_item_t pending_hits[$];
	int errors = 0;
	bit quiet_tail = 0;
	bit hold_off = 0;

	typedef struct {
		vgrt_pkg::in_item_t item;
		bit has_res;
		vgrt_pkg::out_item_t res;
	} row_t;
	row_t rows[$];

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#400ms;
		$display("TB_ERROR");
		$finish;
	end

	function automatic longint eff_n(logic [4:0] r);
		if (r == 0)
			return 1;
		if (r > MAXR)
			return MAXR;
		return longint'(r);
	endfunction

	function automatic longint plane_at(longint o, longint d, longint k, longint n);
		longint num, den;
		num = (2 * k - n) * ONE - n * o;
		den = n * d;
		if (den == 0)
			return 0;
		return (num * ONE) / den;
	endfunction

	function automatic bit solid_at(longint ix, longint iy, longint iz);
		longint a;
		a = (iz * MAXR + iy) * MAXR + ix;
		if (a < 0 || a >= 4096)
			return 0;
		return occ_map[a];
	endfunction

	function automatic vgrt_pkg::out_item_t pack_hit(bit h, logic [2:0] f, longint t);
		vgrt_pkg::out_item_t r;
		if (t > 64'sd2147483647)
			t = 64'sd2147483647;
		if (t < -64'sd2147483648)
			t = -64'sd2147483648;
		r.hit = h;
		r.face = f;
		r.hit_distance = t[31:0];
		return r;
	endfunction

	function automatic vgrt_pkg::out_item_t trace_ray(vgrt_pkg::in_item_t it);
		longint org[3], dir[3], n[3], idx[3], tn[3];
		bit par[3];
		longint tmin, tmax, t1, t2, p, v, m;
		int face, a, f;
		bit start, in_cube;
		in_cube = 1;
		face = -1;
		org[0] = it.origin_x;
		org[1] = it.origin_y;
		org[2] = it.origin_z;
		dir[0] = it.direction_x;
		dir[1] = it.direction_y;
		dir[2] = it.direction_z;
		tmin = it.interval_start;
		tmax = it.interval_end;
		for (int i = 0; i < 3; i++)
			n[i] = eff_n(grid_res[i]);
		for (a = 0; a < 3; a++) begin
			if (dir[a] == 0) begin
				if (org[a] < -ONE || org[a] > ONE)
					return pack_hit(0, vgrt_pkg::FACE_NONE, 0);
				continue;
			end
			t1 = plane_at(org[a], dir[a], 0, n[a]);
			t2 = plane_at(org[a], dir[a], n[a], n[a]);
			if (dir[a] > 0) begin
				if (t1 > tmin) begin
					tmin = t1;
					face = 2 * a;
				end
				if (t2 < tmax)
					tmax = t2;
			end else begin
				if (t2 > tmin) begin
					tmin = t2;
					face = 2 * a + 1;
				end
				if (t1 < tmax)
					tmax = t1;
			end
			if (tmin > tmax)
				return pack_hit(0, vgrt_pkg::FACE_NONE, 0);
		end
		for (a = 0; a < 3; a++) begin
			p = org[a] + (tmin * dir[a]) / ONE;
			v = (p + ONE) * n[a];
			idx[a] = v < 0 ? 0 : v / (2 * ONE);
			if (idx[a] >= n[a])
				idx[a] = n[a] - 1;
			m = dir[a] < 0 ? -dir[a] : dir[a];
			par[a] = m * 1000000 < ONE;
			if (par[a])
				tn[a] = TINF;
			else
				tn[a] = plane_at(org[a], dir[a], dir[a] > 0 ? idx[a] + 1 : idx[a], n[a]);
			if (org[a] < -ONE || org[a] > ONE)
				in_cube = 0;
		end
		start = solid_at(idx[0], idx[1], idx[2]) && in_cube;
		for (int s = 0; s < 3 * MAXR + 4; s++) begin
			if (solid_at(idx[0], idx[1], idx[2]) != start) begin
				if (face < 0)
					f = vgrt_pkg::FACE_NONE;
				else
					f = start ? (face ^ 1) : face;
				return pack_hit(1, f[2:0], tmin);
			end
			if (tn[0] < tn[1] && tn[0] < tn[2])
				a = 0;
			else if (tn[1] < tn[2])
				a = 1;
			else
				a = 2;
			face = 2 * a + (dir[a] > 0 ? 0 : 1);
			tmin = tn[a];
			if (tmin > tmax || par[a])
				return pack_hit(0, vgrt_pkg::FACE_NONE, 0);
			idx[a] += dir[a] > 0 ? 1 : -1;
			if (idx[a] < 0 || idx[a] >= n[a])
				return pack_hit(0, vgrt_pkg::FACE_NONE, 0);
			tn[a] = plane_at(org[a], dir[a], dir[a] > 0 ? idx[a] + 1 : idx[a], n[a]);
		end
		return pack_hit(0, vgrt_pkg::FACE_NONE, 0);
	endfunction

	function automatic vgrt_pkg::in_item_t write_item(int addr, bit occ);
		vgrt_pkg::in_item_t it;
		it = '0;
		it.mode = vgrt_pkg::MODE_WRITE;
		it.voxel_address = addr[11:0];
		it.voxel_occupied = occ;
		it.origin_x = $urandom;
		it.direction_z = $urandom;
		return it;
	endfunction

	function automatic vgrt_pkg::in_item_t ray_item(int ox, int oy, int oz, int dx, int dy,
			int dz, int t0, int t1);
		vgrt_pkg::in_item_t it;
		it.mode = vgrt_pkg::MODE_TRACE;
		it.voxel_address = 12'($urandom);
		it.voxel_occupied = 1'($urandom);
		it.origin_x = ox;
		it.origin_y = oy;
		it.origin_z = oz;
		it.direction_x = dx;
		it.direction_y = dy;
		it.direction_z = dz;
		it.interval_start = t0;
		it.interval_end = t1;
		return it;
	endfunction

	function automatic int rand_coord();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return $urandom_range(0, 2) == 0 ? 32'sh10000 : -32'sh10000;
			default: return $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
		endcase
	endfunction

	function automatic int rand_dir();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return 0;
			2: return $signed($urandom_range(0, 2)) - 1;
			default: return $signed($urandom_range(0, 32'h30000)) - 32'sh18000;
		endcase
	endfunction

	function automatic vgrt_pkg::in_item_t rand_ray();
		int t0, t1;
		t0 = $urandom_range(0, 4) == 0 ? int'($urandom) : -32'sh100000;
		t1 = $urandom_range(0, 4) == 0 ? int'($urandom) : 32'sh100000;
		return ray_item(rand_coord(), rand_coord(), rand_coord(),
			rand_dir(), rand_dir(), rand_dir(), t0, t1);
	endfunction

	task automatic drain_then_idle();
		in_valid <= 0;
		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (8000) @(posedge clk);
	endtask

	task automatic set_grid(int rx, int ry, int rz);
		int v[3];
		v = '{rx, ry, rz};
		for (int i = 0; i < 3; i++) begin
			cfg_we <= 1;
			cfg_addr <= i[1:0];
			cfg_wdata <= v[i][4:0];
			grid_res[i] = v[i][4:0];
			@(posedge clk);
		end
		cfg_we <= 0;
	endtask

	task automatic send(vgrt_pkg::in_item_t it, bit has_res, vgrt_pkg::out_item_t res);
		if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1;
		in_item <= it;
		do
			@(posedge clk);
		while (!in_ready);
		if (it.mode == vgrt_pkg::MODE_WRITE) begin
			occ_map[it.voxel_address] = it.voxel_occupied;
		end else begin
			if (!has_res)
				res = trace_ray(it);
			pending_hits.push_back(res);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			vgrt_pkg::out_item_t e;
			if (pending_hits.size() == 0) begin
				$error("unexpected result item");
				errors++;
			end else begin
				e = pending_hits.pop_front();
				if (out_item.hit !== e.hit) begin
					$error("hit exp %0d got %0d", e.hit, out_item.hit);
					errors++;
				end
				if (out_item.face !== e.face) begin
					$error("face exp %0d got %0d", e.face, out_item.face);
					errors++;
				end
				if (out_item.hit_distance !== e.hit_distance) begin
					$error("hit_distance exp %0d got %0d", e.hit_distance,
						out_item.hit_distance);
					errors++;
				end
			end
		end
	end

	initial begin
		out_ready <= 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off)
				out_ready <= 0;
			else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
				out_ready <= 0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_ready <= 1;
			end else
				out_ready <= 1;
		end
	end

	initial begin
		vgrt_pkg::out_item_t miss;
		vgrt_pkg::in_item_t it;
		int cfgs[6][3];
		arst_n = 0;
		in_valid = 0;
		in_item = '0;
		cfg_we = 0;
		cfg_addr = 0;
		cfg_wdata = 0;
		for (int i = 0; i < 3; i++)
			grid_res[i] = 1;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		miss = pack_hit(0, vgrt_pkg::FACE_NONE, 0);

		// directed
		rows.push_back('{ray_item(0, 0, 0, 32'sh10000, 0, 0, -32'sh20000, 32'sh20000), 1, miss});
		rows.push_back('{ray_item(32'sh20000, 0, 0, 0, 32'sh10000, 0, 0, 32'sh10000), 1, miss});
		rows.push_back('{write_item(0, 1), 0, miss});
		rows.push_back('{ray_item(-32'sh30000, 0, 0, 32'sh10000, 0, 0, 0, 32'sh100000), 1,
			pack_hit(1, 0, 32'sh20000)});
		rows.push_back('{ray_item(32'sh30000, 0, 0, -32'sh10000, 0, 0, 0, 32'sh100000), 1,
			pack_hit(1, 1, 32'sh20000)});
		rows.push_back('{ray_item(-32'sh30000, 0, 0, 32'sh10000, 0, 0, 32'sh30000,
			32'sh100000), 1, pack_hit(1, vgrt_pkg::FACE_NONE, 32'sh30000)});
		rows.push_back('{write_item(4095, 1), 0, miss});
		rows.push_back('{write_item(0, 0), 0, miss});
		rows.push_back('{ray_item(32'h7fffffff, 32'h80000000, 0, 32'h80000000, 32'h7fffffff,
			1, 32'h80000000, 32'h7fffffff), 0, miss});
		rows.push_back('{ray_item(0, 0, 0, 1, 1, 1, 0, 32'h7fffffff), 0, miss});
		foreach (rows[i])
			send(rows[i].item, rows[i].has_res, rows[i].res);
		drain_then_idle();

		cfgs = '{'{16, 16, 16}, '{0, 31, 4}, '{4, 4, 4}, '{2, 8, 1}, '{31, 0, 16}, '{3, 5, 7}};
		for (int ph = 0; ph < 6; ph++) begin
			set_grid(cfgs[ph][0], cfgs[ph][1], cfgs[ph][2]);
			if (ph == 1) begin
				fork
					begin
						hold_off = 1;
						repeat (3000) @(posedge clk);
						hold_off = 0;
					end
				join_none
			end
			if (ph == 5)
				quiet_tail = 1;
			for (int k = 0; k < NUM_RAND / 6; k++) begin
				if ($urandom_range(0, 2) == 0)
					it = write_item($urandom_range(0, 4095), 1'($urandom));
				else
					it = rand_ray();
				send(it, 0, miss);
			end
			drain_then_idle();
		end

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
